[rtl/polygon_border_rasterizer_assert.svh]
// Assertion macros for the polygon border rasterizer.
`ifndef POLYGON_BORDER_RASTERIZER_ASSERT_SVH
`define POLYGON_BORDER_RASTERIZER_ASSERT_SVH

// Checked only outside reset.
`define PBR_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pbr assertion failed");

// Checked through reset as well.
`define PBR_ASSERT_RST(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("pbr reset assertion failed");

`endif

[rtl/pbr_pkg.sv]
// Shared types, constants and helpers for the polygon border rasterizer.
package pbr_pkg;

  localparam int ROWS       = 256;
  localparam int COLS       = 256;
  localparam int LABEL_BITS = 8;

  localparam int STORE_ROWS = (ROWS < 256) ? ROWS : 256;
  localparam int STORE_COLS = (COLS < 256) ? COLS : 256;
  localparam int ROW_AW     = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
  localparam int COL_AW     = (STORE_COLS > 1) ? $clog2(STORE_COLS) : 1;
  localparam int ADDR_W     = ROW_AW + COL_AW;
  localparam int DEPTH      = 1 << ADDR_W;
  localparam int LW         = (LABEL_BITS < 8) ? LABEL_BITS : 8;

  localparam int CW  = 12;
  localparam int PW  = 2 * CW;
  localparam int GW  = 11;

  localparam logic REQ_VERTEX = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] label;
    logic       first_vertex;
    logic       last_vertex;
  } req_t;

  typedef struct packed {
    logic [7:0] read_label;
    logic       read_valid;
  } rsp_t;

  typedef struct packed {
    logic          en;
    coord_t        row;
    coord_t        col;
    logic [LW-1:0] label;
  } wr_t;

  function automatic logic in_store(coord_t r, coord_t c);
    return (r >= 0) && (r < coord_t'(STORE_ROWS)) && (c >= 0) && (c < coord_t'(STORE_COLS));
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(coord_t r, coord_t c);
    return {r[ROW_AW-1:0], c[COL_AW-1:0]};
  endfunction

  function automatic coord_t sgn(coord_t v);
    coord_t s;
    s = '0;
    if (v > 0) s = coord_t'(1);
    else if (v < 0) s = -coord_t'(1);
    return s;
  endfunction

  function automatic coord_t absv(coord_t v);
    return (v < 0) ? -v : v;
  endfunction

endpackage

[rtl/polygon_border_rasterizer.sv]
// Top level of the polygon border rasterizer.
//
//  channel | dir | word  | handshake
//  req     | in  | req_t | req_valid / req_stall
//  rsp     | out | rsp_t | rsp_valid / rsp_stall
//
// After reset the label store is swept clear, one entry a cycle, with req_stall
// high throughout. A read passes through the registered store port.
// A vertex writes one pixel per cycle on axis-aligned segments; a sloped step
// waits on the 26-step divider shared by both walk axes.
// rsp is held in an output register; a full, stalled rsp holds a read.
module polygon_border_rasterizer (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pbr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pbr_pkg::rsp_t rsp
);

  typedef enum logic [2:0] {
    T_CLEAR, T_IDLE, T_RD, T_RDW, T_SEG1, T_WAIT1, T_SEG2, T_WAIT2
  } tstate_t;

  tstate_t                      state;
  pbr_pkg::req_t                cur;
  logic [7:0]                   prev_row, prev_col, start_row, start_col;
  logic                         oob;

  logic                         accept;
  logic                         walk_start;
  logic                         walk_done;
  logic [7:0]                   wy0, wx0, wy1, wx1;
  pbr_pkg::wr_t                 wr;
  logic [pbr_pkg::LW:0]         rd_data;
  logic                         store_ready;

  assign req_stall  = (state != T_IDLE);
  assign accept     = req_valid && !req_stall;
  assign walk_start = (state == T_SEG1) || (state == T_SEG2);

  always_comb begin
    if (state == T_SEG2) begin
      wy0 = cur.row;
      wx0 = cur.col;
      wy1 = start_row;
      wx1 = start_col;
    end else begin
      wy0 = cur.first_vertex ? cur.row : prev_row;
      wx0 = cur.first_vertex ? cur.col : prev_col;
      wy1 = cur.row;
      wx1 = cur.col;
    end
  end

  pbr_walk u_walk (
    .clk   (clk),
    .rst   (rst),
    .start (walk_start),
    .y0_in (wy0),
    .x0_in (wx0),
    .y1_in (wy1),
    .x1_in (wx1),
    .lab   (cur.label[pbr_pkg::LW-1:0]),
    .wr    (wr),
    .done  (walk_done)
  );

  pbr_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (state == T_RD),
    .rd_addr (pbr_pkg::store_addr(pbr_pkg::coord_t'(cur.row), pbr_pkg::coord_t'(cur.col))),
    .rd_data (rd_data),
    .ready   (store_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_CLEAR;
      rsp_valid <= 1'b0;
      prev_row  <= '0;
      prev_col  <= '0;
      start_row <= '0;
      start_col <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        T_CLEAR: begin
          if (store_ready) state <= T_IDLE;
        end
        T_IDLE: begin
          if (accept) begin
            cur <= req;
            oob <= !pbr_pkg::in_store(pbr_pkg::coord_t'(req.row),
                                      pbr_pkg::coord_t'(req.col));
            if (req.req_type == pbr_pkg::REQ_READ) begin
              state <= T_RD;
            end else begin
              if (req.first_vertex) begin
                start_row <= req.row;
                start_col <= req.col;
              end
              state <= T_SEG1;
            end
          end
        end
        T_RD: state <= T_RDW;
        T_RDW: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid       <= 1'b1;
            rsp.read_valid  <= !oob && rd_data[pbr_pkg::LW];
            rsp.read_label  <= (!oob && rd_data[pbr_pkg::LW]) ?
                               8'(rd_data[pbr_pkg::LW-1:0]) : 8'h00;
            state           <= T_IDLE;
          end
        end
        T_SEG1: state <= T_WAIT1;
        T_WAIT1: begin
          if (walk_done) begin
            if (cur.last_vertex) begin
              state <= T_SEG2;
            end else begin
              prev_row <= cur.row;
              prev_col <= cur.col;
              state    <= T_IDLE;
            end
          end
        end
        T_SEG2: state <= T_WAIT2;
        T_WAIT2: begin
          if (walk_done) begin
            prev_row <= cur.row;
            prev_col <= cur.col;
            state    <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

[rtl/pbr_div.sv]
// Iterative rounding divider: floor(p/q + 1/2), one quotient bit per cycle.
module pbr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [pbr_pkg::PW-1:0] p,
  input  pbr_pkg::coord_t             q,
  output logic                        done,
  output pbr_pkg::coord_t             res
);

  localparam int NW   = pbr_pkg::PW + 2;
  localparam int RW   = pbr_pkg::CW + 2;
  localparam int CNTW = $clog2(NW);

  logic                        busy;
  logic [CNTW-1:0]             cnt;
  logic [NW-1:0]               num;
  logic [RW-1:0]               rem;
  logic [RW-1:0]               d;
  logic                        neg;

  logic [pbr_pkg::CW-1:0]      qq;
  logic signed [pbr_pkg::PW-1:0] pp;
  logic signed [NW-1:0]        n;
  logic [NW-1:0]               mag;
  logic [RW-1:0]               rem_sh;
  logic                        qbit;
  logic [RW-1:0]               rem_next;
  logic [NW-1:0]               num_next;

  always_comb begin
    qq       = q[pbr_pkg::CW-1] ? pbr_pkg::CW'(-q) : pbr_pkg::CW'(q);
    pp       = q[pbr_pkg::CW-1] ? -p : p;
    n        = (NW'(pp) <<< 1) + $signed({{(NW-pbr_pkg::CW){1'b0}}, qq});
    mag      = n[NW-1] ? NW'(-n) : NW'(n);
    rem_sh   = {rem[RW-2:0], num[NW-1]};
    qbit     = (rem_sh >= d);
    rem_next = qbit ? (rem_sh - d) : rem_sh;
    num_next = {num[NW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      num  <= mag;
      rem  <= '0;
      d    <= {1'b0, qq, 1'b0};
      neg  <= n[NW-1];
    end else if (busy) begin
      num <= num_next;
      rem <= rem_next;
      cnt <= cnt + 1'b1;
      if (cnt == CNTW'(NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
        res  <= pbr_pkg::CW'(neg ? -(num_next + NW'(rem_next != '0)) : num_next);
      end
    end
  end

endmodule

[rtl/pbr_store.sv]
// Label store with clearing sweep after reset.
module pbr_store (
  input  logic                         clk,
  input  logic                         rst,
  input  pbr_pkg::wr_t                 wr,
  input  logic                         rd_en,
  input  logic [pbr_pkg::ADDR_W-1:0]   rd_addr,
  output logic [pbr_pkg::LW:0]         rd_data,
  output logic                         ready
);

  logic [pbr_pkg::LW:0]       mem [pbr_pkg::DEPTH];
  logic [pbr_pkg::ADDR_W:0]   clr_cnt;

  assign ready = clr_cnt[pbr_pkg::ADDR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (!ready) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ready) begin
      mem[clr_cnt[pbr_pkg::ADDR_W-1:0]] <= '0;
    end else if (wr.en && pbr_pkg::in_store(wr.row, wr.col)) begin
      mem[pbr_pkg::store_addr(wr.row, wr.col)] <= {1'b1, wr.label};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/pbr_walk.sv]
// Segment walker: steps one outline segment, using the shared divider.
module pbr_walk (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [7:0]              y0_in,
  input  logic [7:0]              x0_in,
  input  logic [7:0]              y1_in,
  input  logic [7:0]              x1_in,
  input  logic [pbr_pkg::LW-1:0]  lab,
  output pbr_pkg::wr_t            wr,
  output logic                    done
);

  typedef enum logic [3:0] {
    W_IDLE, W_FIRST, W_VERT, W_HORZ, W_OUT, W_OMUL, W_OWAIT, W_IN, W_IMUL, W_IWAIT
  } wstate_t;

  wstate_t                        state;
  pbr_pkg::coord_t                x, y, x0, y0, x1, y1, dx, dy, sx, sy, ys, st;
  logic [pbr_pkg::GW-1:0]         guard;
  logic signed [pbr_pkg::PW-1:0]  prod;
  logic [pbr_pkg::LW-1:0]         labr;

  logic                           div_start;
  logic                           div_done;
  pbr_pkg::coord_t                div_q;
  pbr_pkg::coord_t                div_res;
  pbr_pkg::coord_t                ys_c;
  pbr_pkg::coord_t                diff;
  logic                           jump;

  assign div_start = (state == W_OMUL) || (state == W_IMUL);
  assign div_q     = (state == W_OMUL) ? dx : dy;

  pbr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .p     (prod),
    .q     (div_q),
    .done  (div_done),
    .res   (div_res)
  );

  always_comb begin
    ys_c     = y0 + div_res;
    diff     = ys_c - y;
    jump     = (diff > pbr_pkg::coord_t'(1)) || (diff < -pbr_pkg::coord_t'(1));
    wr.en    = 1'b0;
    wr.row   = y;
    wr.col   = x;
    wr.label = labr;
    case (state)
      W_FIRST: wr.en = 1'b1;
      W_VERT: begin
        wr.en  = (y != y1);
        wr.row = y + sy;
      end
      W_HORZ: begin
        wr.en  = (x != x1);
        wr.col = x + sx;
      end
      W_OWAIT: begin
        wr.en  = div_done && !jump;
        wr.row = ys_c;
        wr.col = x + sx;
      end
      W_IWAIT: begin
        wr.en  = div_done;
        wr.col = x0 + div_res;
      end
      default: wr.en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= W_IDLE;
    end else begin
      case (state)
        W_IDLE: begin
          if (start) begin
            x0    <= pbr_pkg::coord_t'(x0_in);
            y0    <= pbr_pkg::coord_t'(y0_in);
            x1    <= pbr_pkg::coord_t'(x1_in);
            y1    <= pbr_pkg::coord_t'(y1_in);
            x     <= pbr_pkg::coord_t'(x0_in);
            y     <= pbr_pkg::coord_t'(y0_in);
            dx    <= pbr_pkg::coord_t'(x1_in) - pbr_pkg::coord_t'(x0_in);
            dy    <= pbr_pkg::coord_t'(y1_in) - pbr_pkg::coord_t'(y0_in);
            sx    <= pbr_pkg::sgn(pbr_pkg::coord_t'(x1_in) - pbr_pkg::coord_t'(x0_in));
            sy    <= pbr_pkg::sgn(pbr_pkg::coord_t'(y1_in) - pbr_pkg::coord_t'(y0_in));
            labr  <= lab;
            state <= W_FIRST;
          end
        end
        W_FIRST: begin
          if (dx == '0) begin
            state <= W_VERT;
          end else if (dy == '0) begin
            state <= W_HORZ;
          end else begin
            guard <= pbr_pkg::GW'((pbr_pkg::absv(dx) + pbr_pkg::absv(dy)) * 2 + 4);
            state <= W_OUT;
          end
        end
        W_VERT: begin
          if (y == y1) begin
            done  <= 1'b1;
            state <= W_IDLE;
          end else begin
            y <= y + sy;
          end
        end
        W_HORZ: begin
          if (x == x1) begin
            done  <= 1'b1;
            state <= W_IDLE;
          end else begin
            x <= x + sx;
          end
        end
        W_OUT: begin
          if (((x == x1) && (y == y1)) || (guard == '0)) begin
            done  <= 1'b1;
            state <= W_IDLE;
          end else begin
            guard <= guard - 1'b1;
            prod  <= dy * (x + sx - x0);
            state <= W_OMUL;
          end
        end
        W_OMUL: state <= W_OWAIT;
        W_OWAIT: begin
          if (div_done) begin
            if (jump) begin
              ys    <= ys_c;
              st    <= pbr_pkg::sgn(diff);
              state <= W_IN;
            end else begin
              y     <= ys_c;
              x     <= x + sx;
              state <= W_OUT;
            end
          end
        end
        W_IN: begin
          if (y == ys) begin
            state <= W_OUT;
          end else begin
            y     <= y + st;
            prod  <= dx * (y + st - y0);
            state <= W_IMUL;
          end
        end
        W_IMUL: state <= W_IWAIT;
        W_IWAIT: begin
          if (div_done) begin
            x     <= x0 + div_res;
            state <= W_IN;
          end
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule

[rtl/pbr_checker.sv]
// Port-level checker for the polygon border rasterizer, bound to the top.
`include "polygon_border_rasterizer_assert.svh"

module pbr_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input pbr_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input pbr_pkg::rsp_t rsp
);

  logic req_word;
  logic vtx_word;

  assign req_word = req_valid && !req_stall;
  assign vtx_word = req_word && (req.req_type == pbr_pkg::REQ_VERTEX);

  `PBR_ASSERT_RST(a_reset_quiet, clk, rst |=> req_stall && !rsp_valid)
  `PBR_ASSERT(a_busy_after_accept, clk, rst, req_word |=> req_stall)
  `PBR_ASSERT(a_vertex_no_word, clk, rst, vtx_word && !rsp_valid |=> !rsp_valid)
  `PBR_ASSERT(a_empty_label_zero, clk, rst, rsp_valid && !rsp.read_valid |-> rsp.read_label == 8'h00)
  `PBR_ASSERT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))

endmodule

bind polygon_border_rasterizer pbr_checker u_pbr_checker (.*);
